/* sv/p2tw_pkg.sv */
// ----------------------------------------------------------------------------
// p2tw_pkg
// shared types and field widths of the power-of-two timeout bucket wheel
// ----------------------------------------------------------------------------
package p2tw_pkg;

  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned TICKS_W = 32;

  typedef enum logic {
    CMD_ARM  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [SLOT_W-1:0]   slot;
    logic [TICKS_W-1:0]  ticks;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] expired_slot;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

/* sv/pow2_timeout_bucket_wheel_core.sv */
// ----------------------------------------------------------------------------
// pow2_timeout_bucket_wheel_core
// per-slot timeouts sorted into power-of-two buckets; a tick walks the buckets
// of every changed clock bit and reports the slots that ran out
// ----------------------------------------------------------------------------
//
//  channel  ports                       transfer when
//  -------  --------------------------  ------------------------------
//  input    start, busy, in_data        start high and busy low
//  result   out_valid, out_data         out_valid high (one cycle each)
//
//  an arm keeps busy low, so the next item may follow at once
//  a tick keeps busy high after its transfer while it walks n orders of buckets,
//  n being 1..ORDER_COUNT, with one memory read per slot per walk
//  at most one result per cycle, the last one on the first cycle after busy drops
//  the receiver cannot stall results; the final result of a tick is marked last
//  synchronous reset clears the clock, the active mask and all slots to untimed
//
module pow2_timeout_bucket_wheel_core #(
  parameter int unsigned ORDER_COUNT = 8,
  parameter int unsigned SLOT_COUNT  = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  p2tw_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output p2tw_pkg::out_item_t  out_data
);
  import p2tw_pkg::*;

  localparam int unsigned SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned ORD_W   = $clog2(ORDER_COUNT);
  localparam int unsigned BKT_W   = $clog2(2 * ORDER_COUNT);
  localparam int unsigned MEM_W   = BKT_W + TICKS_W;

  // size order of a timeout length: largest i below ORDER_COUNT with len >= 2^(i+1), else 0
  function automatic logic [ORD_W-1:0] order_of(input logic [TICKS_W-1:0] len);
    logic [ORD_W-1:0] ord;
    ord = '0;
    for (int unsigned i = 1; i < ORDER_COUNT; i++) begin
      if ((len >> (i + 1)) != '0) ord = ORD_W'(i);
    end
    return ord;
  endfunction

  function automatic logic [BKT_W-1:0] bucket_of(input logic [ORD_W-1:0] ord,
                                                 input logic act);
    logic [BKT_W-1:0] b;
    b = BKT_W'(ord);
    if (!act) b = b + BKT_W'(ORDER_COUNT);
    return b;
  endfunction

  // slot memory: bucket number and deadline per slot
  logic [MEM_W-1:0] slot_mem [SLOT_COUNT];
  logic [MEM_W-1:0] mem_q_r;
  logic             mem_we;
  logic             mem_re;
  logic [SLOT_AW-1:0] mem_wa;
  logic [MEM_W-1:0] mem_wd;

  state_t                  state_r, state_nxt;
  logic [TICKS_W-1:0]      clock_r, clock_nxt;
  logic [ORDER_COUNT-1:0]  changed_r, changed_nxt;
  logic [ORDER_COUNT-1:0]  active_r, active_nxt;
  logic [ORD_W-1:0]        ord_r, ord_nxt;
  logic [SLOT_AW-1:0]      idx_r, idx_nxt;
  logic                    p_vld_r, p_vld_nxt;
  logic [SLOT_AW-1:0]      p_slot_r, p_slot_nxt;
  logic [SLOT_COUNT-1:0]   timed_r, timed_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [SLOT_AW-1:0]      pend_slot_r, pend_slot_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic [BKT_W-1:0]        walk_bkt;
  logic [BKT_W-1:0]        q_bkt;
  logic [TICKS_W-1:0]      q_deadline;
  logic [TICKS_W-1:0]      remain;
  logic                    member;
  logic                    expired;
  logic [ORD_W-1:0]        rearm_ord;
  logic [ORD_W-1:0]        arm_ord;
  logic [ORD_W:0]          ord_inc;
  logic [ORDER_COUNT-1:0]  chg_sh;
  logic                    slot_ok;
  logic [SLOT_AW-1:0]      in_idx;

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= slot_mem[idx_r];
  end

  assign walk_bkt   = bucket_of(ord_r, ~active_r[ord_r]);
  assign q_bkt      = mem_q_r[MEM_W-1:TICKS_W];
  assign q_deadline = mem_q_r[TICKS_W-1:0];
  assign remain     = q_deadline - clock_r;
  assign member     = timed_r[p_slot_r] && (q_bkt == walk_bkt);
  // deadline equal to the clock or one behind it
  assign expired    = (remain == '0) || (remain == '1);
  assign rearm_ord  = order_of(remain);
  assign arm_ord    = order_of(in_data.ticks);
  assign ord_inc    = {1'b0, ord_r} + (ORD_W + 1)'(1);
  assign chg_sh     = changed_r >> ord_inc;
  assign slot_ok    = ({1'b0, in_data.slot} < (SLOT_W + 1)'(SLOT_COUNT));
  assign in_idx     = in_data.slot[SLOT_AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    clock_nxt     = clock_r;
    changed_nxt   = changed_r;
    active_nxt    = active_r;
    ord_nxt       = ord_r;
    idx_nxt       = idx_r;
    p_vld_nxt     = 1'b0;
    p_slot_nxt    = idx_r;
    timed_nxt     = timed_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wa        = p_slot_r;
    mem_wd        = {bucket_of(rearm_ord, active_r[rearm_ord]), q_deadline};

    // slot read last cycle: expire it or move it to its new bucket
    if (p_vld_r && member) begin
      if (expired) begin
        timed_nxt[p_slot_r] = 1'b0;
        // hold one expiry back so the final one can be marked last
        if (pend_vld_r) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.expired_slot = SLOT_W'(pend_slot_r);
          out_data_nxt.last         = 1'b0;
        end
        pend_vld_nxt  = 1'b1;
        pend_slot_nxt = p_slot_r;
      end else begin
        mem_we = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.command == CMD_TICK) begin
            clock_nxt   = clock_r + TICKS_W'(1);
            changed_nxt = ORDER_COUNT'(clock_r ^ (clock_r + TICKS_W'(1)));
            ord_nxt     = '0;
            idx_nxt     = '0;
            state_nxt   = ST_SCAN;
          end else if (slot_ok) begin
            mem_we            = 1'b1;
            mem_wa            = in_idx;
            mem_wd            = {bucket_of(arm_ord, active_r[arm_ord]),
                                 clock_r + in_data.ticks};
            timed_nxt[in_idx] = (in_data.ticks != '0);
          end
        end
      end
      ST_SCAN: begin
        mem_re     = 1'b1;
        p_vld_nxt  = 1'b1;
        p_slot_nxt = idx_r;
        idx_nxt    = idx_r + SLOT_AW'(1);
        if (idx_r == SLOT_AW'(SLOT_COUNT - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        active_nxt[ord_r] = ~active_r[ord_r];
        idx_nxt           = '0;
        if (chg_sh[0]) begin
          ord_nxt   = ord_r + ORD_W'(1);
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (pend_vld_r) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.expired_slot = SLOT_W'(pend_slot_r);
          out_data_nxt.last         = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clock_r     <= '0;
      changed_r   <= '0;
      active_r    <= '0;
      ord_r       <= '0;
      idx_r       <= '0;
      p_vld_r     <= 1'b0;
      timed_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      changed_r   <= changed_nxt;
      active_r    <= active_nxt;
      ord_r       <= ord_nxt;
      idx_r       <= idx_nxt;
      p_vld_r     <= p_vld_nxt;
      timed_r     <= timed_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_slot_r    <= p_slot_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // every result comes out of a tick walk
  a_out_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside a tick walk");

  // the held-back expiry is always flushed before going idle
  a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r)
    else $error("pending expiry left behind");

  // slot processing only follows a scan read
  a_proc_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("slot processed outside a walk");

  // a walk always covers at least order 0
  a_walk_bit0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> changed_r[0])
    else $error("walk without a changed low clock bit");
`endif

endmodule

/* dv/pow2_timeout_bucket_wheel_core_tb.sv */
// ----------------------------------------------------------------------------
// pow2_timeout_bucket_wheel_core_tb
// self-checking bench for the power-of-two timeout bucket wheel: a queued
// command driver, a strobe monitor and a timer wheel predictor
// that works out the expiries of every tick as it is transferred
// ----------------------------------------------------------------------------
module pow2_timeout_bucket_wheel_core_tb;
  import p2tw_pkg::*;

  localparam int unsigned ORDERS     = 8;
  localparam int unsigned SLOTS      = 64;
  localparam int          LIMIT      = 1500000;
  localparam int          TAIL       = 600;
  localparam int          PHASE_SIZE = 140;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  pow2_timeout_bucket_wheel_core #(
    .ORDER_COUNT(ORDERS),
    .SLOT_COUNT (SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // predictor state of the wheel
  logic [31:0]       wheel_clock = '0;
  logic [ORDERS-1:0] half_sel = '0;
  logic              slot_armed [SLOTS];
  logic [4:0]        slot_bkt [SLOTS];
  logic [31:0]       slot_due [SLOTS];

  in_item_t  cmd_queue [$];
  out_item_t expiry_queue [$];
  out_item_t due_item;
  int        sender_idle_pct = 8;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        queued_items = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic void place_slot(input int s, input logic [31:0] len);
    int ord;
    ord = 0;
    slot_due[s] = wheel_clock + len;
    if (len == 32'd0) begin
      slot_armed[s] = 1'b0;
      slot_bkt[s]   = '0;
      return;
    end
    for (int i = 1; i < ORDERS; i++) begin
      if (64'(len) >= (64'd1 << (i + 1))) ord = i;
    end
    slot_armed[s] = 1'b1;
    slot_bkt[s]   = 5'(half_sel[ord] ? ord : ord + ORDERS);
  endfunction

  function automatic void advance_wheel();
    logic [31:0] changed;
    logic [31:0] dl;
    logic        member [SLOTS];
    int          bkt;
    int          found;
    out_item_t   hit;
    found = 0;
    changed = wheel_clock;
    wheel_clock = wheel_clock + 32'd1;
    changed = changed ^ wheel_clock;
    for (int ord = 0; ord < ORDERS; ord++) begin
      if (changed[ord]) begin
        bkt = half_sel[ord] ? ord + ORDERS : ord;
        // members are fixed before the walk so a re-placed slot is not seen twice
        for (int s = 0; s < SLOTS; s++) member[s] = slot_armed[s] && slot_bkt[s] == bkt;
        for (int s = 0; s < SLOTS; s++) begin
          if (member[s]) begin
            slot_armed[s] = 1'b0;
            slot_bkt[s]   = '0;
            dl = slot_due[s];
            if (dl != wheel_clock && dl + 32'd1 != wheel_clock) begin
              place_slot(s, dl - wheel_clock);
            end else begin
              hit.expired_slot = SLOT_W'(s);
              hit.last         = 1'b0;
              expiry_queue.push_back(hit);
              found++;
            end
          end
        end
        half_sel[ord] = ~half_sel[ord];
      end
    end
    if (found > 0) begin
      hit = expiry_queue.pop_back();
      hit.last = 1'b1;
      expiry_queue.push_back(hit);
    end
  endfunction

  function automatic void predict_item(input in_item_t it);
    if (it.command == CMD_ARM) begin
      if (it.slot < SLOTS) place_slot(int'(it.slot), it.ticks);
    end else begin
      advance_wheel();
    end
  endfunction

  task automatic queue_arm(input int s, input logic [31:0] len);
    in_item_t it;
    it.command = CMD_ARM;
    it.slot    = SLOT_W'(s);
    it.ticks   = len;
    cmd_queue.push_back(it);
    queued_items++;
  endtask

  task automatic queue_tick();
    in_item_t it;
    it.command = CMD_TICK;
    it.slot    = SLOT_W'($urandom());
    it.ticks   = $urandom();
    cmd_queue.push_back(it);
    queued_items++;
  endtask

  function automatic logic [31:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 60) return 32'($urandom_range(1, 16));
    if (r < 82) return 32'($urandom_range(17, 300));
    // order boundaries, one either side
    if (r < 92) return (32'd1 << $urandom_range(1, 8)) + 32'($urandom_range(0, 2)) - 32'd1;
    return $urandom();
  endfunction

  // bursts of arms followed by runs of ticks so that deadlines actually come due
  task automatic queue_random(input int target);
    int n_arm;
    int n_tick;
    int s;
    while (queued_items < target) begin
      n_arm  = $urandom_range(0, 5);
      n_tick = $urandom_range(1, 10);
      for (int k = 0; k < n_arm; k++) begin
        s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, SLOTS - 1);
        queue_arm(s, pick_length());
      end
      for (int k = 0; k < n_tick; k++) queue_tick();
    end
  endtask

  // driver: holds an item until its transfer, idles at random when free
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        predict_item(cmd_queue.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        start   <= 1'b1;
        in_data <= cmd_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe is one transfer, checked against the oldest expiry
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expiry_queue.size() == 0) begin
        flag_mismatch($sformatf("unexpected expiry of slot %0d last %0b",
                                out_data.expired_slot, out_data.last));
      end else begin
        due_item = expiry_queue.pop_front();
        if (out_data.expired_slot !== due_item.expired_slot)
          flag_mismatch($sformatf("expired_slot %0d, want %0d",
                                  out_data.expired_slot, due_item.expired_slot));
        if (out_data.last !== due_item.last)
          flag_mismatch($sformatf("last %0b on slot %0d, want %0b",
                                  out_data.last, due_item.expired_slot, due_item.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_armed[s] = 1'b0;
      slot_bkt[s]   = '0;
      slot_due[s]   = '0;
    end

    // directed: field extremes, parking, re-arming, order boundaries, wrap
    queue_arm(0, 32'd1);
    queue_arm(63, 32'd2);
    queue_arm(5, 32'd0);
    queue_arm(7, 32'd3);
    queue_arm(7, 32'd4);
    queue_arm(10, 32'hFFFF_FFFF);
    queue_arm(11, 32'd256);
    queue_arm(12, 32'd255);
    queue_arm(13, 32'd1);
    queue_arm(13, 32'd0);
    queue_arm(20, 32'd8);
    queue_arm(21, 32'd7);
    queue_arm(30, 32'h8000_0000);
    repeat (8) queue_tick();
    // a slot that already expired, armed again
    queue_arm(0, 32'd1);
    repeat (2) queue_tick();

    queue_random(PHASE_SIZE);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (cmd_queue.size() == 0);
    @(posedge clk);
    sender_idle_pct = 47;
    queue_random(2 * PHASE_SIZE);

    wait (cmd_queue.size() == 0);
    @(posedge clk);
    sender_idle_pct = 0;
    queue_random(3 * PHASE_SIZE);

    wait (cmd_queue.size() == 0);
    while (expiry_queue.size() != 0 || busy || start) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (expiry_queue.size() != 0)
      flag_mismatch($sformatf("%0d expiries never reported", expiry_queue.size()));
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
